>>> hdl/conv1d_relu_multichannel_defines.svh
// ----------------------------------------------------------------------------
// conv1d_relu_multichannel assertion macros
// shared concurrent assertion forms for the convolution block
// ----------------------------------------------------------------------------
`ifndef CONV1D_RELU_MULTICHANNEL_DEFINES_SVH
`define CONV1D_RELU_MULTICHANNEL_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define C1D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("conv1d check failed");

// next-cycle implication, disabled while reset is asserted
`define C1D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("conv1d check failed");

`endif

>>> hdl/conv1d_pkg.sv
// ----------------------------------------------------------------------------
// conv1d_pkg
// sizes, codes and field widths of the multichannel convolution block
// ----------------------------------------------------------------------------
`default_nettype none

package conv1d_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_TAPS     = 16;

    localparam int CHAN_W    = $clog2(MAX_CHANNELS);
    localparam int TAP_W     = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
    localparam int WADDR_W   = CHAN_W + TAP_W;
    localparam int WDEPTH    = MAX_CHANNELS * MAX_TAPS;

    localparam int DATA_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + TAP_W;
    localparam int FRAC_W    = 15;
    localparam int SUM_W     = ACC_W - FRAC_W + 1;
    localparam int ACT_W     = 15;

    localparam int CH_CFG_W  = 4;
    localparam int TAP_CFG_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_WEIGHT  = 2'd1,
        OP_BIAS    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNELS = 1'b0,
        REG_TAPS     = 1'b1
    } t_cfg_reg;

endpackage

`default_nettype wire

>>> hdl/conv1d_relu_multichannel.sv
// ----------------------------------------------------------------------------
// conv1d_relu_multichannel
// streaming single-input, multi-output 1d convolution with relu, q1.15
// ----------------------------------------------------------------------------
// A request is a sample, a tap weight load, a bias load or a window restart.
// Loads and restarts do not start a run. A sample that fills the window to the
// configured tap count T starts a run over the N channels in use: one shared
// 16x16 multiplier walks the taps of each channel through a three-stage
// pipeline (weight memory read, multiply, accumulate); a run waits while the
// result side stalls. The input is not ready during a run. Results leave
// through an output register, one per channel in channel order, the last one
// flagged. Weights and biases are undefined until loaded. The user must write
// configuration only while idle; the block itself does not enforce this.
`default_nettype none

`include "conv1d_relu_multichannel_defines.svh"

module conv1d_relu_multichannel (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [conv1d_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [conv1d_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // request channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [1:0]                            i_operation,
    input  wire logic signed [conv1d_pkg::DATA_W-1:0]  i_sample,
    input  wire logic [2:0]                            i_channel_index,
    input  wire logic [3:0]                            i_tap_index,
    input  wire logic signed [conv1d_pkg::DATA_W-1:0]  i_load_value,
    // result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [2:0]                                 o_out_channel,
    output logic [conv1d_pkg::ACT_W-1:0]               o_activation,
    output logic                                       o_last
);
    import conv1d_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_POST
    } t_state;

    // sequencer and configuration
    t_state                    r_state;
    logic [CH_CFG_W-1:0]       r_channels_in_use;
    logic [TAP_CFG_W-1:0]      r_taps_in_use;
    logic [TAP_CNT_W-1:0]      r_fill;
    logic [CHAN_W-1:0]         r_chan;
    logic [TAP_W-1:0]          r_tap;
    logic                      r_issue_done;
    logic                      r_v1;
    logic                      r_v2;
    logic signed [ACC_W-1:0]   r_acc;

    // storage
    logic signed [DATA_W-1:0]  r_window [MAX_TAPS];
    logic signed [DATA_W-1:0]  r_bias   [MAX_CHANNELS];
    logic signed [DATA_W-1:0]  r_weight_mem [WDEPTH];

    // pipeline data
    logic signed [DATA_W-1:0]  r_wdata;
    logic signed [DATA_W-1:0]  r_xdata;
    logic signed [PROD_W-1:0]  r_prod;

    // result register
    logic                      r_out_valid;
    logic [2:0]                r_out_channel;
    logic [ACT_W-1:0]          r_activation;
    logic                      r_last;

    logic [CH_CFG_W-1:0]       nc_eff;
    logic [TAP_CFG_W-1:0]      nt_eff;
    logic                      in_fire;
    logic [TAP_CNT_W-1:0]      n_fill;
    logic                      tap_last;
    logic                      chan_last;
    logic [TAP_W-1:0]          win_pos;
    logic [WADDR_W-1:0]        rd_addr;
    logic signed [SUM_W-1:0]   n_sum;
    logic [ACT_W-1:0]          n_activation;
    logic                      out_free;

    // clamp register values into their legal ranges
    always_comb begin
        nc_eff = r_channels_in_use;
        if (r_channels_in_use == '0) begin
            nc_eff = CH_CFG_W'(1);
        end else if (r_channels_in_use > CH_CFG_W'(MAX_CHANNELS)) begin
            nc_eff = CH_CFG_W'(MAX_CHANNELS);
        end
        nt_eff = r_taps_in_use;
        if (r_taps_in_use == '0) begin
            nt_eff = TAP_CFG_W'(1);
        end else if (r_taps_in_use > TAP_CFG_W'(MAX_TAPS)) begin
            nt_eff = TAP_CFG_W'(MAX_TAPS);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // fill count saturates at the window depth
    assign n_fill = (r_fill < TAP_CNT_W'(MAX_TAPS)) ? r_fill + TAP_CNT_W'(1) : r_fill;

    assign tap_last  = (TAP_CFG_W'(r_tap) == nt_eff - TAP_CFG_W'(1));
    assign chan_last = (CH_CFG_W'(r_chan) + CH_CFG_W'(1) == nc_eff);

    // tap j pairs with the sample T-1-j steps back from the newest
    assign win_pos = TAP_W'(nt_eff - TAP_CFG_W'(1) - TAP_CFG_W'(r_tap));
    assign rd_addr = {r_chan, r_tap};

    // floor shift of the sum, bias add, then relu with saturation
    always_comb begin
        n_sum = SUM_W'(r_acc >>> FRAC_W) + SUM_W'(r_bias[r_chan]);
        if (n_sum <= 0) begin
            n_activation = '0;
        end else if (n_sum > SUM_W'(32767)) begin
            n_activation = {ACT_W{1'b1}};
        end else begin
            n_activation = n_sum[ACT_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // weight memory: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_fire && (t_op'(i_operation) == OP_WEIGHT)) begin
            r_weight_mem[{i_channel_index, i_tap_index}] <= i_load_value;
        end
        r_wdata <= r_weight_mem[rd_addr];
    end

    // window operand register and the shared multiplier
    always_ff @(posedge i_clk) begin
        r_xdata <= r_window[win_pos];
        r_prod  <= r_wdata * r_xdata;
    end

    // bias registers, undefined until loaded
    always_ff @(posedge i_clk) begin
        if (in_fire && (t_op'(i_operation) == OP_BIAS)) begin
            r_bias[i_channel_index] <= i_load_value;
        end
    end

    // sequencer, window, accumulator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_channels_in_use <= CH_CFG_W'(MAX_CHANNELS);
            r_taps_in_use     <= TAP_CFG_W'(MAX_TAPS);
            r_fill            <= '0;
            r_chan            <= '0;
            r_tap             <= '0;
            r_issue_done      <= 1'b0;
            r_v1              <= 1'b0;
            r_v2              <= 1'b0;
            r_acc             <= '0;
            r_out_valid       <= 1'b0;
            r_out_channel     <= '0;
            r_activation      <= '0;
            r_last            <= 1'b0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_window[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_CHANNELS: r_channels_in_use <= i_cfg_data[CH_CFG_W-1:0];
                    REG_TAPS:     r_taps_in_use     <= i_cfg_data[TAP_CFG_W-1:0];
                    default:      ;
                endcase
            end

            // pipeline valid flags follow the issued taps
            r_v1 <= (r_state == S_MAC) && !r_issue_done;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end

            // a new result loads the register, otherwise an accepted one leaves
            if ((r_state == S_POST) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (t_op'(i_operation))
                            OP_SAMPLE: begin
                                r_window[0] <= i_sample;
                                for (int k = 1; k < MAX_TAPS; k++) begin
                                    r_window[k] <= r_window[k-1];
                                end
                                r_fill <= n_fill;
                                if (TAP_CFG_W'(n_fill) >= nt_eff) begin
                                    r_state      <= S_MAC;
                                    r_chan       <= '0;
                                    r_tap        <= '0;
                                    r_issue_done <= 1'b0;
                                    r_acc        <= '0;
                                end
                            end
                            OP_RESTART: begin
                                r_fill <= '0;
                                for (int k = 0; k < MAX_TAPS; k++) begin
                                    r_window[k] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAC: begin
                    if (!r_issue_done) begin
                        if (tap_last) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_tap <= r_tap + TAP_W'(1);
                        end
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (out_free) begin
                        r_out_channel <= 3'(r_chan);
                        r_activation  <= n_activation;
                        r_last        <= chan_last;
                        if (chan_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state      <= S_MAC;
                            r_chan       <= r_chan + CHAN_W'(1);
                            r_tap        <= '0;
                            r_issue_done <= 1'b0;
                            r_acc        <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_activation  = r_activation;
    assign o_last        = r_last;

    // the flagged result carries the highest channel in use
    `C1D_ASSERT_SAME(a_last_channel, i_clk, i_rst_n, o_out_valid && o_last, CH_CFG_W'(o_out_channel) == nc_eff - CH_CFG_W'(1))
    // a sample that completes the window starts a run
    `C1D_ASSERT_NEXT(a_run_start, i_clk, i_rst_n, in_fire && (t_op'(i_operation) == OP_SAMPLE) && (TAP_CFG_W'(n_fill) >= nt_eff), r_state == S_MAC)
    // the pipeline is drained before a result is formed
    `C1D_ASSERT_SAME(a_post_drained, i_clk, i_rst_n, r_state == S_POST, !r_v1 && !r_v2)
    // fill count never passes the window depth
    `C1D_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= TAP_CNT_W'(MAX_TAPS))

endmodule

`default_nettype wire
